// ----- rtl/npt_pkg.sv -----
// Shared constants, control word and status types for the perceptron trainer.
// Holds the microcode program as a function. No dependencies.
package npt_pkg;

  localparam int NUM_ATTR = 9;
  localparam int ATTR_W   = 16;
  localparam int WGT_W    = 32;
  localparam int LR_W     = 16;
  localparam int SUM_W    = 32;
  localparam int CLS_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int IDX_W    = (NUM_ATTR > 1) ? $clog2(NUM_ATTR) : 1;

  // multiplier: A takes weight, error or step; B takes attribute or learning rate
  localparam int MA_W     = WGT_W + 1;
  localparam int MB_W     = ATTR_W + 1;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int ACC_W    = PROD_W + IDX_W;
  localparam int STEP_W   = MA_W;

  localparam logic [LR_W-1:0] LR_RESET = 16'd6554;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] upc_t;

  localparam upc_t UA_IDLE  = 4'd0;
  localparam upc_t UA_DOT   = 4'd1;
  localparam upc_t UA_DRAIN = 4'd2;
  localparam upc_t UA_SUM   = 4'd3;
  localparam upc_t UA_ERR   = 4'd4;
  localparam upc_t UA_STEP  = 4'd5;
  localparam upc_t UA_WAIT  = 4'd6;
  localparam upc_t UA_UPD   = 4'd7;
  localparam upc_t UA_FLUSH = 4'd8;
  localparam upc_t UA_OUT   = 4'd9;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_DOT,
    MUL_STEP,
    MUL_UPD
  } mul_sel_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_MORE_IDX,
    C_CLASSIFY,
    C_ERR_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic     take;
    mul_sel_t mul_sel;
    logic     idx_clr;
    logic     idx_inc;
    logic     sum_ld;
    logic     err_ld;
    logic     out_ld;
    cond_t    cond;
    upc_t     target;
    logic     ret;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic more_idx;
    logic classify;
    logic err_zero;
    logic out_busy;
  } status_t;

  // control store: one word per step, jump to target when the condition holds
  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t cw;
    cw         = '0;
    cw.mul_sel = MUL_NONE;
    cw.cond    = C_NEVER;
    cw.target  = UA_IDLE;
    case (pc)
      UA_IDLE: begin
        cw.take    = 1'b1;
        cw.idx_clr = 1'b1;
        cw.cond    = C_NO_INPUT;
        cw.target  = UA_IDLE;
      end
      UA_DOT: begin
        cw.mul_sel = MUL_DOT;
        cw.idx_inc = 1'b1;
        cw.cond    = C_MORE_IDX;
        cw.target  = UA_DOT;
      end
      UA_DRAIN: begin
        cw.cond = C_NEVER;
      end
      UA_SUM: begin
        cw.sum_ld = 1'b1;
      end
      UA_ERR: begin
        cw.err_ld  = 1'b1;
        cw.idx_clr = 1'b1;
        cw.cond    = C_CLASSIFY;
        cw.target  = UA_OUT;
      end
      UA_STEP: begin
        cw.mul_sel = MUL_STEP;
        cw.cond    = C_ERR_ZERO;
        cw.target  = UA_OUT;
      end
      UA_WAIT: begin
        cw.cond = C_NEVER;
      end
      UA_UPD: begin
        cw.mul_sel = MUL_UPD;
        cw.idx_inc = 1'b1;
        cw.cond    = C_MORE_IDX;
        cw.target  = UA_UPD;
      end
      UA_FLUSH: begin
        cw.cond = C_NEVER;
      end
      UA_OUT: begin
        cw.out_ld = 1'b1;
        cw.cond   = C_OUT_BUSY;
        cw.target = UA_OUT;
        cw.ret    = 1'b1;
      end
      default: begin
        cw.ret = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/npt_ifs.sv -----
// Channel interfaces of the perceptron trainer: sample input, result output
// and learning-rate write. Depends on npt_pkg for field widths.
interface npt_in_if import npt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [ATTR_W-1:0] population;
  logic signed [ATTR_W-1:0] population_change;
  logic signed [ATTR_W-1:0] age_share;
  logic signed [ATTR_W-1:0] black_share;
  logic signed [ATTR_W-1:0] hispanic_share;
  logic signed [ATTR_W-1:0] bachelor_share;
  logic signed [ATTR_W-1:0] income_level;
  logic signed [ATTR_W-1:0] poverty_share;
  logic signed [ATTR_W-1:0] density_level;
  logic                     label;

  modport source (
    output valid, operation, population, population_change, age_share, black_share,
           hispanic_share, bachelor_share, income_level, poverty_share, density_level,
           label,
    input  ready
  );
  modport sink (
    input  valid, operation, population, population_change, age_share, black_share,
           hispanic_share, bachelor_share, income_level, poverty_share, density_level,
           label,
    output ready
  );
endinterface

interface npt_out_if import npt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] weighted_sum;
  logic signed [CLS_W-1:0] rounded_class;

  modport source (output valid, weighted_sum, rounded_class, input ready);
  modport sink   (input valid, weighted_sum, rounded_class, output ready);
endinterface

interface npt_cfg_if import npt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LR_W-1:0] learning_rate;

  modport source (output valid, learning_rate, input ready);
  modport sink   (input valid, learning_rate, output ready);
endinterface

// ----- rtl/npt_sequencer.sv -----
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on npt_pkg for the program and control/status types.
module npt_sequencer import npt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t stat,
  output ctrl_t   ctrl
);

  upc_t pc_r;
  upc_t pc_nxt;
  logic jump;

  always_comb begin
    ctrl = ucode(pc_r);
  end

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    jump = 1'b0;
      C_NO_INPUT: jump = ~stat.in_valid;
      C_MORE_IDX: jump = stat.more_idx;
      C_CLASSIFY: jump = stat.classify;
      C_ERR_ZERO: jump = stat.err_zero;
      C_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.ret) begin
      pc_nxt = UA_IDLE;
    end else begin
      pc_nxt = pc_r + upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UA_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_take_starts_dot: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == UA_IDLE && stat.in_valid) |=> (pc_r == UA_DOT))
    else $error("accepted word did not start the dot product");

  a_out_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == UA_OUT && !stat.out_busy) |=> (pc_r == UA_IDLE))
    else $error("sequencer did not return to idle after result load");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= UA_OUT)
    else $error("step counter left the program");

endmodule

// ----- rtl/npt_datapath.sv -----
// Datapath: weight and attribute registers, one shared multiplier with a
// tagged product stage, accumulator, rounding and the output register. Uses npt_pkg.
module npt_datapath import npt_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  ctrl_t          ctrl,
  output status_t        stat,
  npt_in_if.sink         in_ch,
  npt_out_if.source      out_ch,
  npt_cfg_if.sink        cfg_ch
);

  localparam int HALF     = 2 ** (FRAC_W - 1);
  localparam int ACC_SH_W = ACC_W - FRAC_W;
  localparam int P_SH_W   = PROD_W - FRAC_W;
  localparam int S_SH_W   = SUM_W + 1 - FRAC_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [CLS_W-1:0] CLS_MAX = {1'b0, {(CLS_W-1){1'b1}}};
  localparam logic signed [CLS_W-1:0] CLS_MIN = {1'b1, {(CLS_W-1){1'b0}}};
  localparam logic signed [WGT_W-1:0] WGT_MAX = {1'b0, {(WGT_W-1){1'b1}}};
  localparam logic signed [WGT_W-1:0] WGT_MIN = {1'b1, {(WGT_W-1){1'b0}}};

  logic                     take;
  logic                     out_load;
  logic [LR_W-1:0]          lr_r;
  logic signed [ATTR_W-1:0] attr_in [NUM_ATTR];
  logic signed [ATTR_W-1:0] attr_r  [NUM_ATTR];
  logic signed [WGT_W-1:0]  wgt_r   [NUM_ATTR];
  logic                     op_r;
  logic                     label_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     more_idx;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_r;
  mul_sel_t                 p_kind_r;
  logic [IDX_W-1:0]         p_idx_r;
  logic signed [WGT_W-1:0]  p_wgt_r;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_SH_W-1:0] acc_sh;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;

  logic signed [SUM_W:0]    s_rnd;
  logic signed [S_SH_W-1:0] s_sh;
  logic signed [CLS_W-1:0]  cls_r;
  logic signed [CLS_W-1:0]  cls_nxt;
  logic signed [MA_W-1:0]   err_r;
  logic signed [MA_W-1:0]   err_nxt;

  logic signed [PROD_W-1:0] p_rnd;
  logic signed [P_SH_W-1:0] p_sh;
  logic signed [STEP_W-1:0] step_r;
  logic signed [STEP_W-1:0] step_nxt;

  logic signed [PROD_W:0]   w_sum;
  logic signed [WGT_W-1:0]  wgt_nxt;

  logic                     out_valid_r;
  logic signed [SUM_W-1:0]  ws_r;
  logic signed [CLS_W-1:0]  rc_r;

  // handshake and status
  assign take         = ctrl.take & in_ch.valid;
  assign in_ch.ready  = ctrl.take;
  assign cfg_ch.ready = 1'b1;
  assign more_idx     = (idx_r != IDX_W'(NUM_ATTR - 1));

  assign stat.in_valid = in_ch.valid;
  assign stat.more_idx = more_idx;
  assign stat.classify = op_r;
  assign stat.err_zero = (err_r == '0);
  assign stat.out_busy = out_valid_r & ~out_ch.ready;

  assign out_load = ctrl.out_ld & ~stat.out_busy;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.weighted_sum  = ws_r;
  assign out_ch.rounded_class = rc_r;

  always_comb begin
    attr_in[0] = in_ch.population;
    attr_in[1] = in_ch.population_change;
    attr_in[2] = in_ch.age_share;
    attr_in[3] = in_ch.black_share;
    attr_in[4] = in_ch.hispanic_share;
    attr_in[5] = in_ch.bachelor_share;
    attr_in[6] = in_ch.income_level;
    attr_in[7] = in_ch.poverty_share;
    attr_in[8] = in_ch.density_level;
  end

  // shared multiplier operand select
  always_comb begin
    case (ctrl.mul_sel)
      MUL_DOT: begin
        mul_a = MA_W'(wgt_r[idx_r]);
        mul_b = MB_W'(attr_r[idx_r]);
      end
      MUL_STEP: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, lr_r});
      end
      MUL_UPD: begin
        mul_a = step_r;
        mul_b = MB_W'(attr_r[idx_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half away from zero: bias by half, one less when negative
  always_comb begin
    acc_rnd = acc_r + (acc_r[ACC_W-1] ? ACC_W'(HALF - 1) : ACC_W'(HALF));
    acc_sh  = acc_rnd[ACC_W-1:FRAC_W];
    if ((&acc_sh[ACC_SH_W-1:SUM_W-1]) | ~(|acc_sh[ACC_SH_W-1:SUM_W-1])) begin
      sum_nxt = acc_sh[SUM_W-1:0];
    end else begin
      sum_nxt = acc_sh[ACC_SH_W-1] ? SUM_MIN : SUM_MAX;
    end
  end

  always_comb begin
    s_rnd = (SUM_W + 1)'(sum_r) + (sum_r[SUM_W-1] ? (SUM_W + 1)'(HALF - 1) :
                                                   (SUM_W + 1)'(HALF));
    s_sh  = s_rnd[SUM_W:FRAC_W];
    if (s_sh[S_SH_W-1] == s_sh[CLS_W-1]) begin
      cls_nxt = s_sh[CLS_W-1:0];
    end else begin
      cls_nxt = s_sh[S_SH_W-1] ? CLS_MIN : CLS_MAX;
    end
    err_nxt = $signed({{(MA_W-FRAC_W-1){1'b0}}, label_r, {FRAC_W{1'b0}}}) - MA_W'(sum_r);
  end

  always_comb begin
    p_rnd    = prod_r + (prod_r[PROD_W-1] ? PROD_W'(HALF - 1) : PROD_W'(HALF));
    p_sh     = p_rnd[PROD_W-1:FRAC_W];
    step_nxt = p_sh[STEP_W-1:0];
  end

  always_comb begin
    w_sum = (PROD_W + 1)'(p_wgt_r) + (PROD_W + 1)'(prod_r);
    if ((&w_sum[PROD_W:WGT_W-1]) | ~(|w_sum[PROD_W:WGT_W-1])) begin
      wgt_nxt = w_sum[WGT_W-1:0];
    end else begin
      wgt_nxt = w_sum[PROD_W] ? WGT_MIN : WGT_MAX;
    end
  end

  // control state, weights and learning rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r        <= LR_RESET;
      idx_r       <= '0;
      p_kind_r    <= MUL_NONE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_ATTR; i++) begin
        wgt_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        lr_r <= cfg_ch.learning_rate;
      end
      if (ctrl.idx_clr) begin
        idx_r <= '0;
      end else if (ctrl.idx_inc && more_idx) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      p_kind_r <= ctrl.mul_sel;
      if (p_kind_r == MUL_UPD) begin
        wgt_r[p_idx_r] <= wgt_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      op_r    <= in_ch.operation;
      label_r <= in_ch.label;
      for (int i = 0; i < NUM_ATTR; i++) begin
        attr_r[i] <= attr_in[i];
      end
    end
    prod_r  <= mul_a * mul_b;
    p_idx_r <= idx_r;
    p_wgt_r <= wgt_r[idx_r];
    if (take) begin
      acc_r <= '0;
    end else if (p_kind_r == MUL_DOT) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (p_kind_r == MUL_STEP) begin
      step_r <= step_nxt;
    end
    if (ctrl.sum_ld) begin
      sum_r <= sum_nxt;
    end
    if (ctrl.err_ld) begin
      err_r <= err_nxt;
      cls_r <= cls_nxt;
    end
    if (out_load) begin
      ws_r <= sum_r;
      rc_r <= cls_r;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(NUM_ATTR - 1))
    else $error("attribute index out of range");

  a_no_update_on_classify: assert property (@(posedge clk) disable iff (!rst_n)
    (p_kind_r == MUL_UPD) |-> !op_r)
    else $error("weight update issued for a classify word");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && ws_r == $past(sum_r) && rc_r == $past(cls_r)))
    else $error("result register not loaded with the current sum");

endmodule

// ----- rtl/nine_input_perceptron_trainer_top.sv -----
// Nine-input linear neuron trained by the delta rule.
// Sample words enter on in_ch (valid/ready): nine signed Q8.8 attributes, a 0/1
// label and an operation (0 train, 1 classify). Each word gives one result word
// on out_ch: the weighted sum before any update (signed Q16.16, saturated) and
// that sum rounded to the nearest integer (saturated to 16 bits).
// cfg_ch writes the learning rate (unsigned Q0.16); ready is always high.
// One shared 33x17 multiplier, driven by a ten-step microcode program, walks the
// nine products of the sum and then, for a train word, the nine weight updates;
// that loop sets the rate. A classify word goes from the error step straight to the
// result register; a train word with zero error skips the updates. Ready returns
// the cycle after the result is loaded, so no new word is taken before that.
// The result register holds a finished word while the sink stalls; the next
// sample is accepted meanwhile, and the program waits in its last step only if
// a second result is ready before the first is taken.
// Reset (rst_n low, synchronous) zeroes all weights, sets the learning rate to
// 6554 (about 0.1), empties the result register and returns to idle.
// Depends on npt_pkg, the channel interfaces, npt_sequencer and npt_datapath.
module nine_input_perceptron_trainer_top import npt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  npt_in_if.sink     in_ch,
  npt_out_if.source  out_ch,
  npt_cfg_if.sink    cfg_ch
);

  ctrl_t   ctrl;
  status_t stat;

  npt_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  npt_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule
